// ----- hw/rtl/hng_pkg.sv -----
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types, widths and codes of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W       = 16;
    localparam int NORMAL_W       = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int MAX_HEIGHT_W   = 24;
    localparam int STEP_W         = 32;
    localparam int ROW_W          = 13;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;
    localparam logic [MAX_HEIGHT_W-1:0]   MAX_HEIGHT_RST   = 24'd256;
    localparam logic [STEP_W-1:0]         STEP_RST         = 32'd65536;

    localparam logic [NORMAL_W-1:0] NORMAL_MID  = 16'd32767;
    localparam logic [NORMAL_W-1:0] NORMAL_FULL = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_MAX_HEIGHT,
        CFG_STEP_X,
        CFG_STEP_Y
    } cfg_index_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RD0,
        T_RD1,
        T_RD2,
        T_MATH,
        T_OUT
    } top_state_t;

    typedef enum logic [4:0] {
        M_IDLE,
        M_MA,
        M_MX0,
        M_MX1,
        M_MC,
        M_MZ0,
        M_MZ1,
        M_MP,
        M_FY,
        M_NORM,
        M_SQX,
        M_SQY,
        M_SQZ,
        M_SQRT,
        M_CHK,
        M_DIV,
        M_DONE
    } math_state_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_Z
    } div_sel_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lb_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nu_status_t;

endpackage

// ----- hw/rtl/hng_if.sv -----
// ----------------------------------------------------------------------------
// hng_if
// Request channels: height samples in, normals out.
// ----------------------------------------------------------------------------
interface hng_sample_if
    import hng_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] height_sample;
    logic                is_flush;

    modport source (output valid, output height_sample, output is_flush, input ready);
    modport sink   (input valid, input height_sample, input is_flush, output ready);
endinterface

interface hng_normal_if
    import hng_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [NORMAL_W-1:0] normal_x;
    logic [NORMAL_W-1:0] normal_y;
    logic [NORMAL_W-1:0] normal_z;
    logic                frame_done;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output frame_done, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input frame_done, output ready);
endinterface

// ----- hw/rtl/heightmap_normal_generator_top.sv -----
// ----------------------------------------------------------------------------
// heightmap_normal_generator_top
// Height samples in raster order in, central-difference surface normals out.
//
// sample_in carries one height sample per request; is_flush requests carry no
// sample and drive out one pixel of the final row (send image_width of them
// after the last row). normal_out carries one normal per pixel of the row
// above the one being received, with frame_done on the last flushed pixel.
// Samples of the first row and requests out of sequence give no normal.
// Each request passes the row store states RD0, RD1 and RD2; when a normal is
// due, the solver around one shared 32x32 multiplier runs its products, scaling
// loop, square root and three divisions (none for a zero length) before the
// normal goes out. sample_in is ready only between requests.
// A finished normal sits in the output register; a stalled receiver holds the
// next normal inside the block, and sample_in stays low until it moves.
// Reset clears the counters and restores the register defaults; the row
// stores are not cleared. cfg_write of image_width or image_height restarts
// the frame. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_top
    import hng_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hng_sample_if.sink             sample_in,
    hng_normal_if.source           normal_out
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    top_state_t state_reg, state_next;

    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;
    logic [MAX_HEIGHT_W-1:0]   max_height_reg;
    logic [STEP_W-1:0]         step_x_reg, step_y_reg;

    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SAMPLE_BITS-1:0] left_reg;

    logic [AW-1:0]          c_reg;
    logic [SAMPLE_BITS-1:0] sample_reg, ac_reg, al_reg, up_reg;
    logic                   flush_reg, last_reg, k_le1_reg, emit_reg, done_reg;

    logic                out_valid_reg;
    logic [NORMAL_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                out_done_reg;

    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             awaiting;
    logic             accept, take_item, geom_write;
    logic [AW-1:0]    c_cur;
    logic [WW-1:0]    c_plus1;
    logic             c_last;
    logic             load_out;

    lb_ctrl_t               lb_ctrl;
    logic [AW-1:0]          lb_addr;
    logic [SAMPLE_BITS-1:0] above_q, two_q;
    logic [SAMPLE_BITS-1:0] ar_w, down_w;
    nu_status_t             nu_stat;
    logic [NORMAL_W-1:0]    nu_x, nu_y, nu_z;

    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(image_width_reg);
    end

    assign eff_h    = (image_height_reg == '0) ? ROW_W'(1) : ROW_W'(image_height_reg);
    assign awaiting = row_reg >= eff_h;

    assign accept     = sample_in.valid && sample_in.ready;
    assign take_item  = accept && (sample_in.is_flush == awaiting);
    assign c_cur      = (WW'(col_reg) >= eff_w) ? '0 : col_reg;
    assign c_plus1    = WW'(c_cur) + 1'b1;
    assign c_last     = c_plus1 >= eff_w;
    assign geom_write = cfg_write && (cfg_index_t'(cfg_index) == CFG_IMAGE_WIDTH ||
                                      cfg_index_t'(cfg_index) == CFG_IMAGE_HEIGHT);
    assign load_out   = state_reg == T_OUT && (!out_valid_reg || normal_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            max_height_reg   <= MAX_HEIGHT_RST;
            step_x_reg       <= STEP_RST;
            step_y_reg       <= STEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMAGE_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMAGE_HEIGHT_W-1:0];
                CFG_MAX_HEIGHT:   max_height_reg   <= cfg_data[MAX_HEIGHT_W-1:0];
                CFG_STEP_X:       step_x_reg       <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:       step_y_reg       <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take_item)
        begin
            col_next = c_last ? '0 : AW'(c_plus1);
            if (c_last)
                row_next = sample_in.is_flush ? '0 : row_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: if (take_item) state_next = T_RD0;
            T_RD0:  state_next = T_RD1;
            T_RD1:  state_next = T_RD2;
            T_RD2:  state_next = emit_reg ? T_MATH : T_IDLE;
            T_MATH: if (nu_stat.done) state_next = T_OUT;
            T_OUT:  if (load_out) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        lb_ctrl = '0;
        lb_addr = c_reg;
        case (state_reg)
            T_RD0: lb_ctrl.rd_en = 1'b1;
            T_RD1:
            begin
                lb_ctrl.rd_en = 1'b1;
                lb_addr       = c_reg + 1'b1;
            end
            T_RD2: lb_ctrl.wr_en = !flush_reg;
            default:
            begin
            end
        endcase
    end

    assign ar_w   = last_reg ? ac_reg : above_q;
    assign down_w = flush_reg ? ac_reg : sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (geom_write)
                left_reg <= '0;
            else if (state_reg == T_RD1)
                left_reg <= above_q;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (normal_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item && state_reg == T_IDLE)
        begin
            c_reg      <= c_cur;
            sample_reg <= sample_in.height_sample[SAMPLE_BITS-1:0];
            flush_reg  <= sample_in.is_flush;
            last_reg   <= c_last;
            k_le1_reg  <= row_reg <= ROW_W'(1);
            emit_reg   <= row_reg != '0;
            done_reg   <= sample_in.is_flush && c_last;
        end
        if (state_reg == T_RD1)
        begin
            ac_reg <= above_q;
            al_reg <= (c_reg == '0) ? above_q : left_reg;
            up_reg <= k_le1_reg ? above_q : two_q;
        end
        if (load_out)
        begin
            out_x_reg    <= nu_x;
            out_y_reg    <= nu_y;
            out_z_reg    <= nu_z;
            out_done_reg <= done_reg;
        end
    end

    hng_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .DW    (SAMPLE_BITS),
        .AW    (AW)
    ) u_line_buffer (
        .clk      (clk),
        .ctrl     (lb_ctrl),
        .addr     (lb_addr),
        .wr_above (sample_reg),
        .wr_two   (ac_reg),
        .above_q  (above_q),
        .two_q    (two_q)
    );

    hng_normal_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_normal_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == T_RD2 && emit_reg),
        .left       (al_reg),
        .right      (ar_w),
        .up         (up_reg),
        .down       (down_w),
        .max_height (max_height_reg),
        .step_x     (step_x_reg),
        .step_y     (step_y_reg),
        .status     (nu_stat),
        .normal_x   (nu_x),
        .normal_y   (nu_y),
        .normal_z   (nu_z)
    );

    assign sample_in.ready       = state_reg == T_IDLE;
    assign normal_out.valid      = out_valid_reg;
    assign normal_out.normal_x   = out_x_reg;
    assign normal_out.normal_y   = out_y_reg;
    assign normal_out.normal_z   = out_z_reg;
    assign normal_out.frame_done = out_done_reg;

`ifndef ASSERT_OFF
    a_done_in_math: assert property (@(posedge clk) disable iff (!rst_n)
        nu_stat.done |-> state_reg == T_MATH)
        else $error("solver finished outside the math phase");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == T_IDLE)
        else $error("loaded normal not presented");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < eff_w)
        else $error("column counter beyond row width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= eff_h)
        else $error("row counter beyond frame height");
`endif

endmodule

// ----- hw/rtl/hng_line_buffer.sv -----
// ----------------------------------------------------------------------------
// hng_line_buffer
// Two row stores (row above, row two above) sharing one address port.
// ----------------------------------------------------------------------------
module hng_line_buffer
    import hng_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int DW    = SAMPLE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
)(
    input  logic          clk,
    input  lb_ctrl_t      ctrl,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wr_above,
    input  logic [DW-1:0] wr_two,
    output logic [DW-1:0] above_q,
    output logic [DW-1:0] two_q
);

    logic [DW-1:0] above_mem_reg [DEPTH];
    logic [DW-1:0] two_mem_reg   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            above_mem_reg[addr] <= wr_above;
            two_mem_reg[addr]   <= wr_two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            above_q <= above_mem_reg[addr];
            two_q   <= two_mem_reg[addr];
        end
    end

endmodule

// ----- hw/rtl/hng_normal_unit.sv -----
// ----------------------------------------------------------------------------
// hng_normal_unit
// Iterative normal solver around one shared 32x32 multiplier: products,
// common scaling, square root and three restoring divisions, or a fixed normal for zero length.
// ----------------------------------------------------------------------------
module hng_normal_unit
    import hng_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SAMPLE_BITS-1:0]  left,
    input  logic [SAMPLE_BITS-1:0]  right,
    input  logic [SAMPLE_BITS-1:0]  up,
    input  logic [SAMPLE_BITS-1:0]  down,
    input  logic [MAX_HEIGHT_W-1:0] max_height,
    input  logic [STEP_W-1:0]       step_x,
    input  logic [STEP_W-1:0]       step_y,
    output nu_status_t              status,
    output logic [NORMAL_W-1:0]     normal_x,
    output logic [NORMAL_W-1:0]     normal_y,
    output logic [NORMAL_W-1:0]     normal_z
);

    localparam int AW2    = SAMPLE_BITS + MAX_HEIGHT_W;
    localparam int VW     = AW2 + STEP_W;
    localparam int YFW    = 2 * STEP_W + SAMPLE_BITS;
    localparam int NORM_W = 31;
    localparam int SQ_W   = 64;
    localparam int L_W    = 32;
    localparam int DEN_W  = L_W + 1;
    localparam int NUM_W  = DEN_W + NORMAL_W;
    localparam int CNT_W  = $clog2(NORMAL_W);

    math_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] dmag_reg, emag_reg;
    logic                   xneg_reg, zneg_reg;
    logic [AW2-1:0]         a_reg;
    logic [VW-1:0]          x_reg, y_reg, z_reg;
    logic [SQ_W-1:0]        acc_reg, root_reg, bit_reg;
    logic [NUM_W-1:0]       rem_reg, dsh_reg;
    logic [NORMAL_W-1:0]    q_reg;
    logic [CNT_W-1:0]       cnt_reg;
    div_sel_t               sel_reg;
    logic [NORMAL_W-1:0]    nx_reg, ny_reg, nz_reg;

    logic [31:0]     mul_a, mul_b;
    logic [63:0]     mul_p;
    logic [YFW-1:0]  y_full;
    logic [VW-1:0]   y_fold;
    logic [VW-1:0]   any_w;
    logic            big;
    logic [SQ_W:0]   rb;
    logic            take;
    logic [L_W-1:0]  l_val;
    div_sel_t        setup_sel;
    logic [DEN_W-1:0] setup_src, setup_den;
    logic [NUM_W-1:0] setup_num, setup_dsh;
    logic            ge;
    logic [NORMAL_W-1:0] q_new;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            M_MA:
            begin
                mul_a = 32'(dmag_reg);
                mul_b = 32'(max_height);
            end
            M_MX0:
            begin
                mul_a = a_reg[31:0];
                mul_b = step_y;
            end
            M_MX1:
            begin
                mul_a = 32'(a_reg >> 32);
                mul_b = step_y;
            end
            M_MC:
            begin
                mul_a = 32'(emag_reg);
                mul_b = 32'(max_height);
            end
            M_MZ0:
            begin
                mul_a = a_reg[31:0];
                mul_b = step_x;
            end
            M_MZ1:
            begin
                mul_a = 32'(a_reg >> 32);
                mul_b = step_x;
            end
            M_MP:
            begin
                mul_a = step_x;
                mul_b = step_y;
            end
            M_SQX:
            begin
                mul_a = 32'(x_reg[NORM_W-1:0]);
                mul_b = 32'(x_reg[NORM_W-1:0]);
            end
            M_SQY:
            begin
                mul_a = 32'(y_reg[NORM_W-1:0]);
                mul_b = 32'(y_reg[NORM_W-1:0]);
            end
            M_SQZ:
            begin
                mul_a = 32'(z_reg[NORM_W-1:0]);
                mul_b = 32'(z_reg[NORM_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign y_full = (YFW'(y_reg[2*STEP_W-1:0]) << SAMPLE_BITS) - YFW'(y_reg[2*STEP_W-1:0]);
    assign y_fold = VW'(y_full >> 8);

    assign any_w = x_reg | y_reg | z_reg;
    assign big   = |any_w[VW-1:NORM_W];

    assign rb    = (SQ_W+1)'(root_reg) + (SQ_W+1)'(bit_reg);
    assign take  = (SQ_W+1)'(acc_reg) >= rb;
    assign l_val = root_reg[L_W-1:0];

    assign setup_sel = (state_reg == M_CHK) ? DIV_X : div_sel_t'(sel_reg + 2'd1);

    always_comb
    begin
        case (setup_sel)
            DIV_X:
            begin
                setup_src = xneg_reg ? DEN_W'(l_val) - DEN_W'(x_reg[NORM_W-1:0])
                                     : DEN_W'(l_val) + DEN_W'(x_reg[NORM_W-1:0]);
                setup_den = {l_val, 1'b0};
            end
            DIV_Y:
            begin
                setup_src = DEN_W'(y_reg[NORM_W-1:0]);
                setup_den = DEN_W'(l_val);
            end
            DIV_Z:
            begin
                setup_src = zneg_reg ? DEN_W'(l_val) - DEN_W'(z_reg[NORM_W-1:0])
                                     : DEN_W'(l_val) + DEN_W'(z_reg[NORM_W-1:0]);
                setup_den = {l_val, 1'b0};
            end
            default:
            begin
                setup_src = '0;
                setup_den = '0;
            end
        endcase
    end

    assign setup_num = (NUM_W'(setup_src) << NORMAL_W) - NUM_W'(setup_src);
    assign setup_dsh = NUM_W'(setup_den) << (NORMAL_W - 1);

    assign ge    = rem_reg >= dsh_reg;
    assign q_new = {q_reg[NORMAL_W-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: if (start) state_next = M_MA;
            M_MA:   state_next = M_MX0;
            M_MX0:  state_next = M_MX1;
            M_MX1:  state_next = M_MC;
            M_MC:   state_next = M_MZ0;
            M_MZ0:  state_next = M_MZ1;
            M_MZ1:  state_next = M_MP;
            M_MP:   state_next = M_FY;
            M_FY:   state_next = M_NORM;
            M_NORM: if (!big) state_next = M_SQX;
            M_SQX:  state_next = M_SQY;
            M_SQY:  state_next = M_SQZ;
            M_SQZ:  state_next = M_SQRT;
            M_SQRT: if (bit_reg[0]) state_next = M_CHK;
            M_CHK:  state_next = (l_val == '0) ? M_DONE : M_DIV;
            M_DIV:  if (cnt_reg == '0 && sel_reg == DIV_Z) state_next = M_DONE;
            M_DONE: state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    xneg_reg <= right > left;
                    dmag_reg <= (right > left) ? right - left : left - right;
                    zneg_reg <= up < down;
                    emag_reg <= (up < down) ? down - up : up - down;
                end
            end
            M_MA:  a_reg <= AW2'(mul_p);
            M_MX0: x_reg <= VW'(mul_p);
            M_MX1: x_reg <= x_reg + (VW'(mul_p) << 32);
            M_MC:  a_reg <= AW2'(mul_p);
            M_MZ0: z_reg <= VW'(mul_p);
            M_MZ1: z_reg <= z_reg + (VW'(mul_p) << 32);
            M_MP:  y_reg <= VW'(mul_p);
            M_FY:  y_reg <= y_fold;
            M_NORM:
            begin
                if (big)
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    z_reg <= z_reg >> 1;
                end
            end
            M_SQX: acc_reg <= mul_p;
            M_SQY: acc_reg <= acc_reg + mul_p;
            M_SQZ:
            begin
                acc_reg  <= acc_reg + mul_p;
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            M_SQRT:
            begin
                if (take)
                begin
                    acc_reg  <= acc_reg - rb[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            M_CHK:
            begin
                if (l_val == '0)
                begin
                    nx_reg <= NORMAL_MID;
                    ny_reg <= NORMAL_FULL;
                    nz_reg <= NORMAL_MID;
                end
                else
                begin
                    sel_reg <= DIV_X;
                    rem_reg <= setup_num;
                    dsh_reg <= setup_dsh;
                    cnt_reg <= CNT_W'(NORMAL_W - 1);
                end
            end
            M_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    case (sel_reg)
                        DIV_X:   nx_reg <= q_new;
                        DIV_Y:   ny_reg <= q_new;
                        DIV_Z:   nz_reg <= q_new;
                        default: nz_reg <= q_new;
                    endcase
                    sel_reg <= setup_sel;
                    rem_reg <= setup_num;
                    dsh_reg <= setup_dsh;
                    cnt_reg <= CNT_W'(NORMAL_W - 1);
                end
                else
                begin
                    q_reg   <= q_new;
                    rem_reg <= ge ? rem_reg - dsh_reg : rem_reg;
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.busy = state_reg != M_IDLE;
    assign status.done = state_reg == M_DONE;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;

endmodule

// ----- bench/heightmap_normal_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// heightmap_normal_generator_top_tb
// Self-checking bench for the heightmap normal generator.
//
// Streams height frames in raster order, followed by flush requests, through
// the sample channel. A bit-exact predictor of the central-difference normal
// solver queues the expected normals, and each normal taken from the output
// channel is checked field by field against the oldest one. Directed frames
// cover the field and register extremes, the edge clamping, the degenerate
// geometry and out-of-sequence requests. Random frames with random geometry
// and scaling follow. Both channels idle in random bursts, but for the last random frames.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_top_tb;
    import hng_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW      = 1024;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 250;

    typedef struct packed {
        logic [NORMAL_W-1:0] nx;
        logic [NORMAL_W-1:0] ny;
        logic [NORMAL_W-1:0] nz;
        logic                done;
    } normal_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hng_sample_if smp_if ();
    hng_normal_if nrm_if ();

    heightmap_normal_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (smp_if.sink),
        .normal_out(nrm_if.source)
    );

    // predictor state
    logic [15:0] row_above [MAXW];
    logic [15:0] row_two_above [MAXW];
    int unsigned row_cnt, col_cnt;
    logic [15:0] left_val;
    logic [IMAGE_WIDTH_W-1:0]  img_w;
    logic [IMAGE_HEIGHT_W-1:0] img_h;
    logic [MAX_HEIGHT_W-1:0]   max_h;
    logic [STEP_W-1:0]         stp_x, stp_y;

    normal_t     expected_normals[$];
    int          errors;
    int          samples_taken;
    int          normals_seen;
    int          frames_done;
    int          idle_cycles;
    bit          quiet;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned eff_width();
        if (img_w == 0) return 1;
        if (img_w > MAXW) return MAXW;
        return img_w;
    endfunction

    function automatic int unsigned eff_height();
        return (img_h == 0) ? 1 : img_h;
    endfunction

    function automatic bit will_take(input bit fl);
        return fl == (row_cnt >= eff_height());
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int i = 32; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= 128'(v)) r = t;
        end
        return r;
    endfunction

    function automatic int unsigned bit_len(input logic [127:0] v);
        for (int i = 127; i >= 0; i--)
            if (v[i]) return i + 1;
        return 0;
    endfunction

    function automatic normal_t solve_normal(input logic [15:0] lft, input logic [15:0] rgt,
                                             input logic [15:0] up, input logic [15:0] dn);
        normal_t      n;
        bit           xneg, zneg;
        logic [15:0]  dmag, emag;
        logic [127:0] xw, yw, zw;
        int unsigned  b, s;
        logic [63:0]  x, y, z, len, xs, zs;
        xneg = rgt > lft;
        zneg = up < dn;
        dmag = xneg ? rgt - lft : lft - rgt;
        emag = zneg ? dn - up : up - dn;
        xw = 128'(dmag) * 128'(max_h) * 128'(stp_y);
        zw = 128'(emag) * 128'(max_h) * 128'(stp_x);
        yw = (128'(stp_x) * 128'(stp_y) * 128'd65535) >> 8;
        b = bit_len(xw);
        if (bit_len(yw) > b) b = bit_len(yw);
        if (bit_len(zw) > b) b = bit_len(zw);
        s = (b > 31) ? b - 31 : 0;
        x = 64'(xw >> s);
        y = 64'(yw >> s);
        z = 64'(zw >> s);
        len = root64(x * x + y * y + z * z);
        n.done = 1'b0;
        if (len == 0)
        begin
            n.nx = NORMAL_MID;
            n.ny = NORMAL_FULL;
            n.nz = NORMAL_MID;
            return n;
        end
        xs = xneg ? len - x : len + x;
        zs = zneg ? len - z : len + z;
        n.nx = 16'((64'd65535 * xs) / (2 * len));
        n.ny = 16'((64'd65535 * y) / len);
        n.nz = 16'((64'd65535 * zs) / (2 * len));
        return n;
    endfunction

    function automatic void predict_normal(input logic [15:0] smp, input bit fl);
        int unsigned w, h, c, k;
        logic [15:0] ac, ar, al, up, dn;
        bit          done;
        normal_t     n;
        w = eff_width();
        h = eff_height();
        done = 1'b0;
        if (!will_take(fl)) return;
        if (col_cnt >= w) col_cnt = 0;
        c = col_cnt;
        k = row_cnt;
        ac = row_above[c];
        ar = (c + 1 < w) ? row_above[c + 1] : ac;
        al = (c == 0) ? ac : left_val;
        up = (k <= 1) ? ac : row_two_above[c];
        dn = fl ? ac : smp;
        left_val = ac;
        if (!fl)
        begin
            row_two_above[c] = ac;
            row_above[c] = smp;
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            if (fl)
            begin
                row_cnt = 0;
                done = 1'b1;
            end
            else
                row_cnt = k + 1;
        end
        col_cnt = c;
        if (k >= 1)
        begin
            n = solve_normal(al, ar, up, dn);
            n.done = done;
            expected_normals = {expected_normals, n};
        end
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val[IMAGE_WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT: img_h = val[IMAGE_HEIGHT_W-1:0];
            CFG_MAX_HEIGHT:   max_h = val[MAX_HEIGHT_W-1:0];
            CFG_STEP_X:       stp_x = val;
            CFG_STEP_Y:       stp_y = val;
            default: ;
        endcase
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT)
        begin
            row_cnt = 0;
            col_cnt = 0;
            left_val = '0;
        end
        @(posedge clk);
    endtask

    task automatic send_request(input logic [15:0] smp, input bit fl);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        smp_if.valid         <= 1'b1;
        smp_if.height_sample <= smp;
        smp_if.is_flush      <= fl;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        predict_normal(smp, fl);
        if (!fl || will_take(1'b1)) samples_taken++;
    endtask

    task automatic settle();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_normals.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // send a whole frame of h rows plus the flush row, with optional noise
    task automatic send_frame(input int unsigned noise_pct);
        int unsigned w, h;
        w = eff_width();
        h = eff_height();
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if ($urandom_range(0, 99) < noise_pct) send_request(rand_sample(), 1'b1);
                send_request(rand_sample(), 1'b0);
            end
        for (int c = 0; c < w; c++)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_request(rand_sample(), 1'b0);
            send_request(rand_sample(), 1'b1);
        end
    endtask

    task automatic test_defaults();
        for (int i = 0; i < 4; i++) send_request(rand_sample(), 1'b0);
        send_request(16'h1234, 1'b1);
        settle();
    endtask

    task automatic test_extremes();
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        write_reg(CFG_MAX_HEIGHT, 32'h00FFFFFF);
        write_reg(CFG_STEP_X, 32'hFFFFFFFF);
        write_reg(CFG_STEP_Y, 1);
        send_request(16'hFFFF, 1'b1);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'hAAAA, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h0000, 1'b1);
        send_request(16'h0001, 1'b1);
        send_request(16'h8000, 1'b0);
        send_request(16'h0000, 1'b1);
        settle();
        write_reg(CFG_MAX_HEIGHT, 0);
        write_reg(CFG_STEP_X, 1);
        write_reg(CFG_STEP_Y, 32'hFFFFFFFF);
        send_frame(0);
        settle();
    endtask

    task automatic test_degenerate_geometry();
        write_reg(CFG_MAX_HEIGHT, 256);
        write_reg(CFG_STEP_X, 65536);
        write_reg(CFG_STEP_Y, 65536);
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_request(16'h4000, 1'b0);
        send_request(16'h0000, 1'b1);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_IMAGE_HEIGHT, 4096);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h7FFF, 1'b0);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 32'h00001FFF);
        write_reg(CFG_IMAGE_WIDTH, 2);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_frame(0);
        settle();
    endtask

    task automatic test_random_frames(input int target, input bit last_part);
        while (samples_taken < target)
        begin
            write_reg(CFG_IMAGE_WIDTH,
                      ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 40));
            write_reg(CFG_IMAGE_HEIGHT, $urandom_range(1, 5));
            case ($urandom_range(0, 4))
                0: write_reg(CFG_MAX_HEIGHT, 32'h00FFFFFF);
                1: write_reg(CFG_MAX_HEIGHT, $urandom_range(0, 4096));
                default: write_reg(CFG_MAX_HEIGHT, $urandom() & 32'h00FFFFFF);
            endcase
            write_reg(CFG_STEP_X, ($urandom_range(0, 5) == 0) ? 32'hFFFFFFFF : $urandom() | 1);
            write_reg(CFG_STEP_Y, ($urandom_range(0, 5) == 0) ? 32'd1 : $urandom() | 1);
            quiet = last_part;
            send_frame(last_part ? 0 : 10);
            settle();
        end
    endtask

    always @(posedge clk)
    begin
        normal_t exp_n;
        if (rst_n && nrm_if.valid && nrm_if.ready)
        begin
            normals_seen++;
            if (nrm_if.frame_done) frames_done++;
            if (expected_normals.size() == 0)
            begin
                $display("%0t: unexpected normal x=%0d y=%0d z=%0d done=%0b", $time,
                         nrm_if.normal_x, nrm_if.normal_y, nrm_if.normal_z,
                         nrm_if.frame_done);
                errors++;
            end
            else
            begin
                exp_n = expected_normals.pop_front();
                if (nrm_if.normal_x !== exp_n.nx)
                begin
                    $display("%0t: normal_x expected %0d actual %0d", $time, exp_n.nx,
                             nrm_if.normal_x);
                    errors++;
                end
                if (nrm_if.normal_y !== exp_n.ny)
                begin
                    $display("%0t: normal_y expected %0d actual %0d", $time, exp_n.ny,
                             nrm_if.normal_y);
                    errors++;
                end
                if (nrm_if.normal_z !== exp_n.nz)
                begin
                    $display("%0t: normal_z expected %0d actual %0d", $time, exp_n.nz,
                             nrm_if.normal_z);
                    errors++;
                end
                if (nrm_if.frame_done !== exp_n.done)
                begin
                    $display("%0t: frame_done expected %0b actual %0b", $time, exp_n.done,
                             nrm_if.frame_done);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        nrm_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            nrm_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!quiet)
            begin
                nrm_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((smp_if.valid && smp_if.ready) || (nrm_if.valid && nrm_if.ready) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("%0t: watchdog expired, %0d normals outstanding", $time,
                         expected_normals.size());
                $display("heightmap_normal_generator_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = CFG_IMAGE_WIDTH;
        cfg_data             = '0;
        smp_if.valid         = 1'b0;
        smp_if.height_sample = '0;
        smp_if.is_flush      = 1'b0;
        errors = 0;
        samples_taken = 0;
        normals_seen = 0;
        frames_done = 0;
        quiet = 1'b0;
        for (int i = 0; i < MAXW; i++)
        begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        row_cnt = 0;
        col_cnt = 0;
        left_val = '0;
        img_w = IMAGE_WIDTH_RST;
        img_h = IMAGE_HEIGHT_RST;
        max_h = MAX_HEIGHT_RST;
        stp_x = STEP_RST;
        stp_y = STEP_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_degenerate_geometry();
        samples_taken = 0;
        test_random_frames(520, 1'b0);
        test_random_frames(600, 1'b1);

        $display("covered %0d normals in %0d frames: edge clamping, register extremes,",
                 normals_seen, frames_done);
        $display("degenerate geometry, out-of-sequence requests, stalls");
        if (errors == 0)
            $display("heightmap_normal_generator_top regression: pass");
        else
            $display("heightmap_normal_generator_top regression: fail");
        $finish;
    end

endmodule

// ----- heightmap_normal_generator_top.f -----
hw/rtl/hng_pkg.sv
hw/rtl/hng_if.sv
hw/rtl/hng_line_buffer.sv
hw/rtl/hng_normal_unit.sv
hw/rtl/heightmap_normal_generator_top.sv
bench/heightmap_normal_generator_top_tb.sv
